[hdl/jet_pkg.sv]
// Shared constants, types and helpers for the Julia escape-time pixel block.
`timescale 1ns / 1ps

package jet_pkg;

  // Image geometry and iteration limit
  localparam int IMG_WIDTH  = 128;
  localparam int IMG_HEIGHT = 128;
  localparam int MAX_ITER   = 17;

  // Fixed field widths
  localparam int PIX_W      = 7;
  localparam int COUNT_W    = 5;
  localparam int CRE_W      = 31;
  localparam int STEP_W     = 29;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // Number formats: Q4.28 values, Q8.56 products
  localparam int Q_W    = 32;
  localparam int FRAC   = 28;
  localparam int PROD_W = 2 * Q_W;
  localparam int SAT_W  = 48;

  localparam int IMG_MAX = (IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT;
  localparam int D_W     = $clog2(IMG_MAX) + 2;
  localparam int ITER_W  = $clog2(MAX_ITER + 1);

  // |z|^2 > 4 in Q8.56
  localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(4) << (2 * FRAC);

  // Register reset values
  localparam logic signed [CRE_W-1:0] CONST_RE_RST   = CRE_W'(134217728);
  localparam logic signed [CRE_W-1:0] CONST_IM_RST   = '0;
  localparam logic [STEP_W-1:0]       PIXEL_STEP_RST = STEP_W'(6710886);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CONST_RE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CONST_IM   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP = CFG_IDX_W'(2);

  // Multiplier operand selection
  typedef enum logic [2:0] {
    MUL_X,
    MUL_Y,
    MUL_RR,
    MUL_II,
    MUL_RI
  } mul_sel_t;

  // Controller -> datapath
  typedef struct packed {
    mul_sel_t             mul_sel;
    logic                 ld_pix;
    logic                 ld_re_start;
    logic                 ld_im_start;
    logic                 ld_rr;
    logic                 ld_diff;
    logic                 ld_z;
    logic                 ld_out;
    logic [COUNT_W-1:0]   count;
  } jet_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic escaped;
    logic out_free;
  } jet_sts_t;

  // Clamp to the signed Q4.28 range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
    logic in_range;
    in_range = (&v[SAT_W-1:Q_W-1]) || !(|v[SAT_W-1:Q_W-1]);
    if (in_range) begin
      return v[Q_W-1:0];
    end else if (v[SAT_W-1]) begin
      return {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      return {1'b0, {(Q_W-1){1'b1}}};
    end
  endfunction

endpackage

[hdl/jet_mul.sv]
// Registered 32x32 signed multiplier shared by all datapath products.
`timescale 1ns / 1ps

module jet_mul (
  input  logic                              clk,
  input  logic signed [jet_pkg::Q_W-1:0]    a,
  input  logic signed [jet_pkg::Q_W-1:0]    b,
  output logic signed [jet_pkg::PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

[hdl/jet_dp.sv]
// Datapath: config registers, start-point mapping, z iteration, escape test, output register.
`timescale 1ns / 1ps

module jet_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_valid,
  input  logic [jet_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [jet_pkg::CFG_DATA_W-1:0]       cfg_data,
  // pixel payload
  input  logic [jet_pkg::PIX_W-1:0]            pixel_x,
  input  logic [jet_pkg::PIX_W-1:0]            pixel_y,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [jet_pkg::COUNT_W-1:0]          escape_count,
  // controller
  input  jet_pkg::jet_cmd_t                    cmd,
  output jet_pkg::jet_sts_t                    sts
);

  logic signed [jet_pkg::CRE_W-1:0]  const_re;
  logic signed [jet_pkg::CRE_W-1:0]  const_im;
  logic [jet_pkg::STEP_W-1:0]        pixel_step;

  logic [jet_pkg::PIX_W-1:0]         pix_x;
  logic [jet_pkg::PIX_W-1:0]         pix_y;
  logic signed [jet_pkg::D_W-1:0]    dx;
  logic signed [jet_pkg::D_W-1:0]    dy;

  logic signed [jet_pkg::Q_W-1:0]    re;
  logic signed [jet_pkg::Q_W-1:0]    im;
  logic signed [jet_pkg::PROD_W-1:0] rr;
  logic signed [jet_pkg::PROD_W-1:0] diff;

  logic signed [jet_pkg::Q_W-1:0]    mul_a;
  logic signed [jet_pkg::Q_W-1:0]    mul_b;
  logic signed [jet_pkg::PROD_W-1:0] prod;
  logic signed [jet_pkg::Q_W-1:0]    step_s;

  logic signed [jet_pkg::Q_W-1:0]    start_val;
  logic signed [jet_pkg::Q_W-1:0]    re_new;
  logic signed [jet_pkg::Q_W-1:0]    im_new;
  logic [jet_pkg::PROD_W-1:0]        mag2;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      const_re   <= jet_pkg::CONST_RE_RST;
      const_im   <= jet_pkg::CONST_IM_RST;
      pixel_step <= jet_pkg::PIXEL_STEP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        jet_pkg::CFG_CONST_RE:   const_re   <= cfg_data[jet_pkg::CRE_W-1:0];
        jet_pkg::CFG_CONST_IM:   const_im   <= cfg_data[jet_pkg::CRE_W-1:0];
        jet_pkg::CFG_PIXEL_STEP: pixel_step <= cfg_data[jet_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Centered offsets, doubled: 2*p - SIZE
  assign dx = $signed(jet_pkg::D_W'({pix_x, 1'b0})) - $signed(jet_pkg::D_W'(jet_pkg::IMG_WIDTH));
  assign dy = $signed(jet_pkg::D_W'({pix_y, 1'b0})) - $signed(jet_pkg::D_W'(jet_pkg::IMG_HEIGHT));
  assign step_s = $signed({{(jet_pkg::Q_W - jet_pkg::STEP_W){1'b0}}, pixel_step});

  always_comb begin
    case (cmd.mul_sel)
      jet_pkg::MUL_X: begin
        mul_a = jet_pkg::Q_W'(dx);
        mul_b = step_s;
      end
      jet_pkg::MUL_Y: begin
        mul_a = jet_pkg::Q_W'(dy);
        mul_b = step_s;
      end
      jet_pkg::MUL_RR: begin
        mul_a = re;
        mul_b = re;
      end
      jet_pkg::MUL_II: begin
        mul_a = im;
        mul_b = im;
      end
      jet_pkg::MUL_RI: begin
        mul_a = re;
        mul_b = im;
      end
      default: begin
        mul_a = re;
        mul_b = im;
      end
    endcase
  end

  jet_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // (d * step) >> 1, clamped
  assign start_val = jet_pkg::sat_q(jet_pkg::SAT_W'(prod >>> 1));

  // re' = ((rr - ii) >> 28) + c_re ; im' = (ri >> 27) + c_im
  assign re_new = jet_pkg::sat_q(jet_pkg::SAT_W'(diff >>> jet_pkg::FRAC)
                                 + jet_pkg::SAT_W'(const_re));
  assign im_new = jet_pkg::sat_q(jet_pkg::SAT_W'(prod >>> (jet_pkg::FRAC - 1))
                                 + jet_pkg::SAT_W'(const_im));

  // rr holds re^2, prod holds im^2 when the controller samples this
  assign mag2 = $unsigned(rr) + $unsigned(prod);

  always_ff @(posedge clk) begin
    if (cmd.ld_pix) begin
      pix_x <= pixel_x;
      pix_y <= pixel_y;
    end
    if (cmd.ld_re_start) begin
      re <= start_val;
    end else if (cmd.ld_z) begin
      re <= re_new;
    end
    if (cmd.ld_im_start) begin
      im <= start_val;
    end else if (cmd.ld_z) begin
      im <= im_new;
    end
    if (cmd.ld_rr) begin
      rr <= prod;
    end
    if (cmd.ld_diff) begin
      diff <= rr - prod;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.ld_out) begin
      escape_count <= cmd.count;
    end
  end

  assign sts.escaped  = mag2 > jet_pkg::ESC_LIMIT;
  assign sts.out_free = !out_valid || out_ready;

endmodule

[hdl/jet_ctrl.sv]
// Controller FSM: sequences the shared multiplier and counts iterations.
`timescale 1ns / 1ps

module jet_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output jet_pkg::jet_cmd_t cmd,
  input  jet_pkg::jet_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_X,
    S_MUL_Y,
    S_SQ_RE,
    S_SQ_IM,
    S_CHK,
    S_UPD,
    S_DONE
  } state_t;

  state_t                     state;
  logic                       first;
  logic [jet_pkg::ITER_W-1:0] iter;
  logic [jet_pkg::ITER_W-1:0] res;
  logic                       last_iter;

  assign last_iter = (iter == jet_pkg::ITER_W'(jet_pkg::MAX_ITER - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      first <= 1'b1;
      iter  <= '0;
      res   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL_X;
            first <= 1'b1;
            iter  <= '0;
          end
        end
        S_MUL_X: state <= S_MUL_Y;
        S_MUL_Y: state <= S_SQ_RE;
        S_SQ_RE: state <= S_SQ_IM;
        S_SQ_IM: state <= S_CHK;
        S_CHK: begin
          if (!first && (sts.escaped || last_iter)) begin
            res   <= sts.escaped ? iter : jet_pkg::ITER_W'(jet_pkg::MAX_ITER);
            state <= S_DONE;
          end else begin
            if (!first) begin
              iter <= iter + 1'b1;
            end
            first <= 1'b0;
            state <= S_UPD;
          end
        end
        S_UPD: state <= S_SQ_RE;
        S_DONE: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.mul_sel     = jet_pkg::MUL_RR;
    cmd.count       = jet_pkg::COUNT_W'(res);
    in_ready        = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.ld_pix  = in_valid;
        cmd.mul_sel = jet_pkg::MUL_X;
      end
      S_MUL_X: cmd.mul_sel = jet_pkg::MUL_X;
      S_MUL_Y: begin
        cmd.ld_re_start = 1'b1;
        cmd.mul_sel     = jet_pkg::MUL_Y;
      end
      S_SQ_RE: begin
        cmd.ld_im_start = first;
        cmd.mul_sel     = jet_pkg::MUL_RR;
      end
      S_SQ_IM: begin
        cmd.ld_rr   = 1'b1;
        cmd.mul_sel = jet_pkg::MUL_II;
      end
      S_CHK: begin
        cmd.ld_diff = 1'b1;
        cmd.mul_sel = jet_pkg::MUL_RI;
      end
      S_UPD:  cmd.ld_z   = 1'b1;
      S_DONE: cmd.ld_out = sts.out_free;
      default: ;
    endcase
  end

  a_ld_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_out |-> sts.out_free)
    else $error("result loaded while output register occupied");

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    iter <= jet_pkg::ITER_W'(jet_pkg::MAX_ITER - 1))
    else $error("iteration counter past limit");

  a_upd_after_first: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> !first)
    else $error("update entered with first-pass flag set");

  a_res_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (res <= jet_pkg::ITER_W'(jet_pkg::MAX_ITER)))
    else $error("escape count out of range");

endmodule

[hdl/julia_escape_time_pixel.sv]
// Top level of the Julia set escape-time pixel evaluator.
`timescale 1ns / 1ps

// Evaluates one pixel at a time. A pixel (pixel_x, pixel_y) is mapped to the
// start point z0 = ((2*x - 128) * step / 2) + i*((2*y - 128) * step / 2) in
// signed Q4.28, then z = z*z + c is iterated up to 17 times; escape_count is
// the index of the first iteration whose result has |z|^2 > 4, or 17 if the
// point never escapes. All products go through one registered 32x32
// multiplier, so the work runs in steps: start-point setup and a first
// squaring pass, then per iteration update z, re^2, im^2, test and re*im.
// The result sits in an output register, so the next input transaction is
// taken while the previous result waits to be read; the block holds off
// only if a second result is ready before the first is taken. Configuration:
// index 0 = real part of c (Q3.28, 31-bit signed), index 1 = imaginary part
// of c, index 2 = pixel step (Q1.28, 29-bit unsigned); other indexes are
// ignored. cfg_ready is always high, and writes are meant to happen only
// while no pixel is in flight.

module julia_escape_time_pixel (
  input  logic                            clk,
  input  logic                            rst,
  // pixel input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [jet_pkg::PIX_W-1:0]       pixel_x,
  input  logic [jet_pkg::PIX_W-1:0]       pixel_y,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [jet_pkg::COUNT_W-1:0]     escape_count,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [jet_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jet_pkg::CFG_DATA_W-1:0]  cfg_data
);

  jet_pkg::jet_cmd_t cmd;
  jet_pkg::jet_sts_t sts;

  // Register writes are never stalled.
  assign cfg_ready = 1'b1;

  // Sequencer: walks setup, squaring and update steps per iteration.
  jet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Arithmetic, configuration registers and the output register.
  jet_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .escape_count (escape_count),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for julia_escape_time_pixel: directed and random pixels.
`timescale 1ns / 1ps

module testbench;
  import jet_pkg::*;

  // Register index with no register behind it; writes must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

  // Signed Q4.28 limits held in 64 bits
  localparam longint Q_HI = (longint'(1) <<< 31) - 1;
  localparam longint Q_LO = -(longint'(1) <<< 31);

  // Register extremes used by the directed and random phases
  localparam logic [CFG_DATA_W-1:0] C_NEG2     = CFG_DATA_W'(-(1 <<< 29));
  localparam logic [CFG_DATA_W-1:0] C_POS2     = CFG_DATA_W'(1 <<< 29);
  localparam logic [CFG_DATA_W-1:0] C_FIELD_HI = {1'b0, {(CFG_DATA_W-1){1'b1}}};
  localparam logic [CFG_DATA_W-1:0] C_FIELD_LO = {1'b1, {(CFG_DATA_W-1){1'b0}}};
  localparam logic [STEP_W-1:0]     STEP_ONE   = STEP_W'(1 << FRAC);

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_PHASES   = 18;
  localparam int PIXELS_PER_PHASE = 88;

  // Tracks the register copy and the escape counts still owed by the block.
  class escape_tracker;
    longint c_re;
    longint c_im;
    longint step;
    logic [COUNT_W-1:0] expected_counts[$];
    int mismatches;

    function new();
      c_re = longint'(CONST_RE_RST);
      c_im = longint'(CONST_IM_RST);
      step = longint'(PIXEL_STEP_RST);
      mismatches = 0;
    endfunction

    function void write_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CONST_RE:   c_re = longint'($signed(data[CRE_W-1:0]));
        CFG_CONST_IM:   c_im = longint'($signed(data[CRE_W-1:0]));
        CFG_PIXEL_STEP: step = longint'(data[STEP_W-1:0]);
        default: ;
      endcase
    endfunction

    function longint clamp_q(input longint v);
      if (v > Q_HI) return Q_HI;
      if (v < Q_LO) return Q_LO;
      return v;
    endfunction

    // (2p - size) * step / 2, floor rounding, clamped to Q4.28
    function longint start_point(input logic [PIX_W-1:0] p, input int size);
      longint d;
      d = 2 * longint'(p) - longint'(size);
      return clamp_q((d * step) >>> 1);
    endfunction

    function logic [COUNT_W-1:0] predict_escape(input logic [PIX_W-1:0] x,
                                                input logic [PIX_W-1:0] y);
      longint re, im, nre, nim;
      longint unsigned mag;
      re = start_point(x, IMG_WIDTH);
      im = start_point(y, IMG_HEIGHT);
      for (int i = 0; i < MAX_ITER; i++) begin
        nre = clamp_q(((re * re - im * im) >>> FRAC) + c_re);
        nim = clamp_q(((re * im) >>> (FRAC - 1)) + c_im);
        re = nre;
        im = nim;
        mag = unsigned'(re * re) + unsigned'(im * im);
        if (mag > ESC_LIMIT) return COUNT_W'(i);
      end
      return COUNT_W'(MAX_ITER);
    endfunction

    function void note_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
      expected_counts.push_back(predict_escape(x, y));
    endfunction

    function void check_count(input logic [COUNT_W-1:0] actual);
      logic [COUNT_W-1:0] want;
      if (expected_counts.size() == 0) begin
        $display("%0t: escape_count with no pixel pending: expected none, actual %0d",
                 $time, actual);
        mismatches++;
        return;
      end
      want = expected_counts.pop_front();
      if (actual !== want) begin
        $display("%0t: escape_count mismatch: expected %0d, actual %0d",
                 $time, want, actual);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_counts.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [PIX_W-1:0]      pixel_x;
  logic [PIX_W-1:0]      pixel_y;
  logic                  out_valid;
  logic                  out_ready;
  logic [COUNT_W-1:0]    escape_count;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Knobs shared by the sender and the receiver
  logic no_idle;   // both sides run flat out while set
  logic hold_req;  // asks the receiver for one long hold-off

  escape_tracker sb;

  julia_escape_time_pixel uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .escape_count (escape_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  // One pixel transaction. Valid drops only when the sender decides to idle,
  // so back-to-back pixels keep valid high across the handoff.
  task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
    if (!no_idle && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      pixel_x  <= PIX_W'($urandom);  // junk payload while idle
      pixel_y  <= PIX_W'($urandom);
      do @(posedge clk); while ($urandom_range(99) < 31);
    end
    in_valid <= 1'b1;
    pixel_x  <= x;
    pixel_y  <= y;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(x, y);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, data);
  endtask

  task automatic load_config(input logic [CFG_DATA_W-1:0] re_v,
                             input logic [CFG_DATA_W-1:0] im_v,
                             input logic [STEP_W-1:0]     step_v);
    cfg_write(CFG_CONST_RE, re_v);
    cfg_write(CFG_CONST_IM, im_v);
    cfg_write(CFG_PIXEL_STEP, CFG_DATA_W'(step_v));
    cfg_valid <= 1'b0;
  endtask

  // Sender pauses until every owed count is back, then a short settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Mostly |c| <= 1 where the set has structure; sometimes range edges or
  // the whole 31-bit field.
  function automatic logic [CFG_DATA_W-1:0] pick_const();
    case ($urandom_range(9))
      0:       return C_NEG2;
      1:       return C_POS2;
      2:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
    endcase
  endfunction

  // Mostly steps that frame roughly +/-0.25 .. +/-4 across the image.
  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(11))
      0:       return STEP_W'(1);
      1:       return STEP_ONE;
      2:       return STEP_W'($urandom);
      3:       return '0;
      default: return STEP_W'($urandom_range(1 << 20, 1 << 24));
    endcase
  endfunction

  // Result side: compare every count transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_count(escape_count);
    end
  end

  // Receiver: random back-pressure, one long hold-off on request.
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= no_idle || ($urandom_range(99) >= 31);
    end
  end

  // Stimulus
  initial begin
    logic [PIX_W-1:0] dir_x[10];
    logic [PIX_W-1:0] dir_y[10];
    dir_x = '{7'd0, 7'd127, 7'd0,   7'd127, 7'd64, 7'd63, 7'd65, 7'd64,  7'd127, 7'd96};
    dir_y = '{7'd0, 7'd127, 7'd127, 7'd0,   7'd64, 7'd63, 7'd64, 7'd127, 7'd64,  7'd80};
    sb        = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    pixel_x   = '0;
    pixel_y   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CONST_RE;
    cfg_data  = '0;
    no_idle   = 1'b0;
    hold_req  = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset values: corners, center (origin), neighbors of center, edges, one interior point
    foreach (dir_x[i]) send_pixel(dir_x[i], dir_y[i]);
    wait_drained();

    // Unused index write must not disturb anything; zero step maps all to origin
    cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));
    load_config(CONST_RE_RST, CONST_IM_RST, '0);
    send_pixel(7'd0, 7'd0);
    send_pixel(7'd127, 7'd127);
    send_pixel(7'd64, 7'd64);
    wait_drained();

    // Widest step: start point clamps at the image corners, iterates overflow
    load_config(CONST_RE_RST, CONST_IM_RST, {STEP_W{1'b1}});
    send_pixel(7'd0, 7'd0);
    send_pixel(7'd127, 7'd127);
    send_pixel(7'd0, 7'd127);
    send_pixel(7'd127, 7'd0);
    wait_drained();

    // c at the limits of its 31-bit field
    load_config(C_FIELD_HI, C_FIELD_LO, STEP_W'(1 << 20));
    send_pixel(7'd64, 7'd64);
    send_pixel(7'd10, 7'd100);
    wait_drained();

    // c at -2 (real part) and +2 (imaginary part)
    load_config(C_NEG2, C_POS2, STEP_W'(1 << 23));
    send_pixel(7'd64, 7'd64);
    send_pixel(7'd1, 7'd126);
    wait_drained();

    // Random phases, each with fresh register values
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       load_config(C_NEG2, C_NEG2, STEP_W'(1));
        1:       load_config(C_POS2, C_POS2, STEP_ONE);
        default: load_config(pick_const(), pick_const(), pick_step());
      endcase
      if (ph == 3) hold_req <= 1'b1;  // fill the block and stall its input
      no_idle = (ph == 5);
      repeat (PIXELS_PER_PHASE) send_pixel(PIX_W'($urandom), PIX_W'($urandom));
      wait_drained();
      no_idle = 1'b0;
    end

    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[julia_escape_time_pixel.f]
hdl/jet_pkg.sv
hdl/jet_mul.sv
hdl/jet_dp.sv
hdl/jet_ctrl.sv
hdl/julia_escape_time_pixel.sv
tb/sv/testbench.sv
